[rtl/bcd_time_of_day_clock_with_edit_top_macros.svh]
// assertion macros shared by the time-of-day clock modules
`ifndef BCD_TIME_OF_DAY_CLOCK_WITH_EDIT_TOP_MACROS_SVH
`define BCD_TIME_OF_DAY_CLOCK_WITH_EDIT_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define BTOD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BTOD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/btod_pkg.sv]
// types, constants and bcd step functions for the time-of-day clock
package btod_pkg;

	localparam int TPS_W              = 16;
	localparam int PRESCALE_WIDTH_DEF = 16;
	localparam logic [TPS_W-1:0] TPS_RESET = 16'd1200;

	localparam logic [3:0] DIG_MAX   = 4'd9;
	localparam logic [3:0] TENS_MAX  = 4'd5;
	localparam logic [3:0] HT_MAX    = 4'd2;
	localparam logic [3:0] HU_AT_TOP = 4'd3;

	localparam logic [1:0] FIELD_SEC = 2'd0;
	localparam logic [1:0] FIELD_MIN = 2'd1;
	localparam logic [1:0] FIELD_HR  = 2'd2;

	typedef enum logic [3:0] {
		OP_TICK    = 4'd0,
		OP_ENTER   = 4'd1,
		OP_COARSER = 4'd2,
		OP_FINER   = 4'd3,
		OP_UP      = 4'd4,
		OP_DOWN    = 4'd5,
		OP_COMMIT  = 4'd6,
		OP_CANCEL  = 4'd7,
		OP_LOAD    = 4'd8
	} op_t;

	// index 0 second units up to index 5 hour tens
	typedef logic [5:0][3:0] digits_t;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] load_hour_tens;
		logic [3:0] load_hour_units;
		logic [2:0] load_minute_tens;
		logic [3:0] load_minute_units;
		logic [2:0] load_second_tens;
		logic [3:0] load_second_units;
	} in_item_t;

	typedef struct packed {
		logic [1:0] shown_hour_tens;
		logic [3:0] shown_hour_units;
		logic [2:0] shown_minute_tens;
		logic [3:0] shown_minute_units;
		logic [2:0] shown_second_tens;
		logic [3:0] shown_second_units;
		logic       editing;
		logic [1:0] field_selected;
		logic       load_rejected;
	} out_item_t;

	// {carry, digit}
	function automatic logic [4:0] dig_up(logic [3:0] d, logic [3:0] lim);
		if (d >= lim) begin
			return {1'b1, 4'd0};
		end
		return {1'b0, d + 4'd1};
	endfunction

	// {borrow, digit}
	function automatic logic [4:0] dig_down(logic [3:0] d, logic [3:0] lim);
		if (d == 4'd0) begin
			return {1'b1, lim};
		end
		if (d > lim) begin
			return {1'b0, lim};
		end
		return {1'b0, d - 4'd1};
	endfunction

	function automatic digits_t hours_up(digits_t t);
		logic [4:0] r;
		if (t[5] >= HT_MAX && t[4] >= HU_AT_TOP) begin
			t[4] = 4'd0;
			t[5] = 4'd0;
		end else begin
			r = dig_up(t[4], DIG_MAX);
			t[4] = r[3:0];
			if (r[4]) begin
				t[5] = {2'b00, t[5][1:0] + 2'd1};
			end
		end
		return t;
	endfunction

	function automatic digits_t hours_down(digits_t t);
		logic [4:0] r;
		if (t[5] == 4'd0 && t[4] == 4'd0) begin
			t[4] = HU_AT_TOP;
			t[5] = HT_MAX;
		end else begin
			r = dig_down(t[4], DIG_MAX);
			t[4] = r[3:0];
			if (r[4]) begin
				t[5] = {2'b00, t[5][1:0] - 2'd1};
			end
		end
		return t;
	endfunction

	function automatic digits_t time_up(digits_t t, logic [1:0] from);
		logic [4:0] r;
		logic       c;
		c = 1'b0;
		if (from == FIELD_SEC) begin
			r = dig_up(t[0], DIG_MAX);
			t[0] = r[3:0];
			if (r[4]) begin
				r = dig_up(t[1], TENS_MAX);
				t[1] = r[3:0];
				c = r[4];
			end
		end
		if (from == FIELD_MIN || c) begin
			c = 1'b0;
			r = dig_up(t[2], DIG_MAX);
			t[2] = r[3:0];
			if (r[4]) begin
				r = dig_up(t[3], TENS_MAX);
				t[3] = r[3:0];
				c = r[4];
			end
		end
		if (from == FIELD_HR || c) begin
			t = hours_up(t);
		end
		return t;
	endfunction

	function automatic digits_t time_down(digits_t t, logic [1:0] from);
		logic [4:0] r;
		logic       c;
		c = 1'b0;
		if (from == FIELD_SEC) begin
			r = dig_down(t[0], DIG_MAX);
			t[0] = r[3:0];
			if (r[4]) begin
				r = dig_down(t[1], TENS_MAX);
				t[1] = r[3:0];
				c = r[4];
			end
		end
		if (from == FIELD_MIN || c) begin
			c = 1'b0;
			r = dig_down(t[2], DIG_MAX);
			t[2] = r[3:0];
			if (r[4]) begin
				r = dig_down(t[3], TENS_MAX);
				t[3] = r[3:0];
				c = r[4];
			end
		end
		if (from == FIELD_HR || c) begin
			t = hours_down(t);
		end
		return t;
	endfunction

endpackage

[rtl/btod_in_if.sv]
// input item channel of the time-of-day clock
interface btod_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] op;
	logic [1:0] load_hour_tens;
	logic [3:0] load_hour_units;
	logic [2:0] load_minute_tens;
	logic [3:0] load_minute_units;
	logic [2:0] load_second_tens;
	logic [3:0] load_second_units;

	modport source (
		output valid, op, load_hour_tens, load_hour_units, load_minute_tens,
			load_minute_units, load_second_tens, load_second_units,
		input ready
	);
	modport sink (
		input valid, op, load_hour_tens, load_hour_units, load_minute_tens,
			load_minute_units, load_second_tens, load_second_units,
		output ready
	);
endinterface

[rtl/btod_out_if.sv]
// result item channel of the time-of-day clock
interface btod_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] shown_hour_tens;
	logic [3:0] shown_hour_units;
	logic [2:0] shown_minute_tens;
	logic [3:0] shown_minute_units;
	logic [2:0] shown_second_tens;
	logic [3:0] shown_second_units;
	logic       editing;
	logic [1:0] field_selected;
	logic       load_rejected;

	modport source (
		output valid, shown_hour_tens, shown_hour_units, shown_minute_tens,
			shown_minute_units, shown_second_tens, shown_second_units, editing,
			field_selected, load_rejected,
		input ready
	);
	modport sink (
		input valid, shown_hour_tens, shown_hour_units, shown_minute_tens,
			shown_minute_units, shown_second_tens, shown_second_units, editing,
			field_selected, load_rejected,
		output ready
	);
endinterface

[rtl/btod_core.sv]
// clock state, prescaler and per-item update logic
`include "bcd_time_of_day_clock_with_edit_top_macros.svh"

module btod_core #(
	parameter int PRESCALE_WIDTH = btod_pkg::PRESCALE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [btod_pkg::TPS_W-1:0] tps,
	input  logic                       fire,
	input  btod_pkg::in_item_t         item,
	output btod_pkg::out_item_t        result
);
	import btod_pkg::*;

	localparam int CMP_W = (PRESCALE_WIDTH + 1 > TPS_W) ? PRESCALE_WIDTH + 1 : TPS_W;

	digits_t                   live_q, live_d;
	digits_t                   ebuf_q, ebuf_d;
	digits_t                   shown;
	logic                      edit_q, edit_d;
	logic [1:0]                field_q, field_d;
	logic [PRESCALE_WIDTH-1:0] presc_q, presc_d;
	logic [PRESCALE_WIDTH:0]   presc_inc;
	logic                      period_done;
	logic                      load_ok;
	logic                      rejected;

	always_comb begin
		live_d   = live_q;
		ebuf_d   = ebuf_q;
		edit_d   = edit_q;
		field_d  = field_q;
		presc_d  = presc_q;
		rejected = 1'b0;

		presc_inc   = {1'b0, presc_q} + {{PRESCALE_WIDTH{1'b0}}, 1'b1};
		period_done = (CMP_W'(presc_inc) >= CMP_W'(tps)) || presc_inc[PRESCALE_WIDTH];

		load_ok = !edit_q
			&& (4'(item.load_hour_tens) <= HT_MAX)
			&& (item.load_hour_units <= DIG_MAX)
			&& ((4'(item.load_hour_tens) < HT_MAX) || (item.load_hour_units <= HU_AT_TOP))
			&& (4'(item.load_minute_tens) <= TENS_MAX)
			&& (item.load_minute_units <= DIG_MAX)
			&& (4'(item.load_second_tens) <= TENS_MAX)
			&& (item.load_second_units <= DIG_MAX);

		case (item.op)
			OP_TICK: begin
				if (!edit_q) begin
					if (period_done) begin
						presc_d = '0;
						live_d  = time_up(live_q, FIELD_SEC);
					end else begin
						presc_d = presc_inc[PRESCALE_WIDTH-1:0];
					end
				end
			end
			OP_ENTER: begin
				if (!edit_q) begin
					ebuf_d  = live_q;
					field_d = FIELD_SEC;
					edit_d  = 1'b1;
				end
			end
			OP_COARSER: begin
				if (edit_q && field_q < FIELD_HR) begin
					field_d = field_q + 2'd1;
				end
			end
			OP_FINER: begin
				if (edit_q && field_q > FIELD_SEC) begin
					field_d = field_q - 2'd1;
				end
			end
			OP_UP: begin
				if (edit_q) begin
					ebuf_d = time_up(ebuf_q, field_q);
				end
			end
			OP_DOWN: begin
				if (edit_q) begin
					ebuf_d = time_down(ebuf_q, field_q);
				end
			end
			OP_COMMIT: begin
				if (edit_q) begin
					live_d = ebuf_q;
					edit_d = 1'b0;
				end
			end
			OP_CANCEL: begin
				edit_d = 1'b0;
			end
			OP_LOAD: begin
				if (load_ok) begin
					live_d = {4'(item.load_hour_tens), item.load_hour_units,
						4'(item.load_minute_tens), item.load_minute_units,
						4'(item.load_second_tens), item.load_second_units};
				end else begin
					rejected = 1'b1;
				end
			end
			default: begin
			end
		endcase

		shown = edit_d ? ebuf_d : live_d;
		result.shown_hour_tens    = shown[5][1:0];
		result.shown_hour_units   = shown[4];
		result.shown_minute_tens  = shown[3][2:0];
		result.shown_minute_units = shown[2];
		result.shown_second_tens  = shown[1][2:0];
		result.shown_second_units = shown[0];
		result.editing            = edit_d;
		result.field_selected     = field_d;
		result.load_rejected      = rejected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			ebuf_q  <= '0;
			edit_q  <= 1'b0;
			field_q <= FIELD_SEC;
			presc_q <= '0;
		end else if (fire) begin
			live_q  <= live_d;
			ebuf_q  <= ebuf_d;
			edit_q  <= edit_d;
			field_q <= field_d;
			presc_q <= presc_d;
		end
	end

	`BTOD_ASSERT_NOW(a_load_refused_in_edit, fire && item.op == OP_LOAD && edit_q, result.load_rejected, "load accepted while editing")
	`BTOD_ASSERT_NEXT(a_enter_starts_edit, fire && item.op == OP_ENTER && !edit_q, edit_q && field_q == FIELD_SEC, "enter edit did not start at seconds")
	`BTOD_ASSERT_NEXT(a_state_holds_idle, !fire, $stable(live_q) && $stable(edit_q) && $stable(presc_q), "state moved without an item")

endmodule

[rtl/bcd_time_of_day_clock_with_edit_top.sv]
// an accepted item is held in the input register, and its result in the result register
// throughput: one item per cycle; the input register and the result register
// each hold one item, so the input stalls only while both are full and unread
// reset: time 00:00:00, edit off, seconds selected, prescaler zero,
// ticks_per_second 1200; reset is asynchronous and leaves no clearing pass
`include "bcd_time_of_day_clock_with_edit_top_macros.svh"

module bcd_time_of_day_clock_with_edit_top #(
	parameter int PRESCALE_WIDTH = btod_pkg::PRESCALE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [btod_pkg::TPS_W-1:0] cfg_data,
	btod_in_if.sink                    in_ch,
	btod_out_if.source                 out_ch
);
	import btod_pkg::*;

	logic [TPS_W-1:0] tps_q;
	logic             valid_s1;
	in_item_t         item_s1;
	logic             out_valid_q;
	out_item_t        result_q;
	out_item_t        result_c;
	logic             advance;
	logic             fire;
	logic             in_fire;

	assign advance      = !out_valid_q || out_ch.ready;
	assign fire         = valid_s1 && advance;
	assign in_ch.ready  = !valid_s1 || advance;
	assign in_fire      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_write) begin
			tps_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.op                <= in_ch.op;
			item_s1.load_hour_tens    <= in_ch.load_hour_tens;
			item_s1.load_hour_units   <= in_ch.load_hour_units;
			item_s1.load_minute_tens  <= in_ch.load_minute_tens;
			item_s1.load_minute_units <= in_ch.load_minute_units;
			item_s1.load_second_tens  <= in_ch.load_second_tens;
			item_s1.load_second_units <= in_ch.load_second_units;
		end
	end

	btod_core #(
		.PRESCALE_WIDTH(PRESCALE_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.tps    (tps_q),
		.fire   (fire),
		.item   (item_s1),
		.result (result_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_c;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.shown_hour_tens    = result_q.shown_hour_tens;
	assign out_ch.shown_hour_units   = result_q.shown_hour_units;
	assign out_ch.shown_minute_tens  = result_q.shown_minute_tens;
	assign out_ch.shown_minute_units = result_q.shown_minute_units;
	assign out_ch.shown_second_tens  = result_q.shown_second_tens;
	assign out_ch.shown_second_units = result_q.shown_second_units;
	assign out_ch.editing            = result_q.editing;
	assign out_ch.field_selected     = result_q.field_selected;
	assign out_ch.load_rejected      = result_q.load_rejected;

	`BTOD_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_q, "processed item produced no result")
	`BTOD_ASSERT_NEXT(a_s1_held_on_stall, valid_s1 && !fire, valid_s1 && $stable(item_s1), "stalled item lost")
	`BTOD_ASSERT_NOW(a_no_overrun, valid_s1 && out_valid_q && !out_ch.ready, !in_ch.ready, "input taken while both registers full")

endmodule

[tb/sv/btod_checker.sv]
// checker for the time-of-day clock: predicts every result item and compares it
`timescale 1ns / 100ps

module btod_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [btod_pkg::TPS_W-1:0] cfg_data,
	btod_in_if                         in_ch,
	btod_out_if                        out_ch,
	output int                         fail_count,
	output int                         pending
);
	import btod_pkg::*;

	localparam int PRESCALE_W = PRESCALE_WIDTH_DEF;
	localparam logic [32:0] COUNT_TOP = (33'd1 << PRESCALE_W) - 33'd1;

	digits_t          live_time;
	digits_t          edit_time;
	logic             edit_on;
	logic [1:0]       field_sel;
	logic [31:0]      tick_count;
	logic [TPS_W-1:0] tps;
	out_item_t        shown_q[$];

	function automatic digits_t step_up(digits_t t, logic [1:0] from);
		logic [3:0] lim;
		int         i;
		int         start;
		logic       carry;
		start = from;
		carry = 1'b1;
		for (i = 2 * start; i < 4 && carry; i++) begin
			lim = (i % 2 == 0) ? DIG_MAX : TENS_MAX;
			if (t[i] >= lim) begin
				t[i] = 4'd0;
			end else begin
				t[i] = t[i] + 4'd1;
				carry = 1'b0;
			end
		end
		if (carry) begin
			if (t[5] >= HT_MAX && t[4] >= HU_AT_TOP) begin
				t[5] = 4'd0;
				t[4] = 4'd0;
			end else if (t[4] >= DIG_MAX) begin
				t[4] = 4'd0;
				t[5] = {2'b00, t[5][1:0] + 2'd1};
			end else begin
				t[4] = t[4] + 4'd1;
			end
		end
		return t;
	endfunction

	function automatic digits_t step_down(digits_t t, logic [1:0] from);
		logic [3:0] lim;
		int         i;
		int         start;
		logic       borrow;
		start = from;
		borrow = 1'b1;
		for (i = 2 * start; i < 4 && borrow; i++) begin
			lim = (i % 2 == 0) ? DIG_MAX : TENS_MAX;
			if (t[i] == 4'd0) begin
				t[i] = lim;
			end else begin
				if (t[i] > lim) begin
					t[i] = lim;
				end else begin
					t[i] = t[i] - 4'd1;
				end
				borrow = 1'b0;
			end
		end
		if (borrow) begin
			if (t[5] == 4'd0 && t[4] == 4'd0) begin
				t[4] = HU_AT_TOP;
				t[5] = HT_MAX;
			end else if (t[4] == 4'd0) begin
				t[4] = DIG_MAX;
				t[5] = {2'b00, t[5][1:0] - 2'd1};
			end else if (t[4] > DIG_MAX) begin
				t[4] = DIG_MAX;
			end else begin
				t[4] = t[4] - 4'd1;
			end
		end
		return t;
	endfunction

	function automatic string show_time(out_item_t r);
		return $sformatf("%0d%0d:%0d%0d:%0d%0d edit=%0d field=%0d rej=%0d",
			r.shown_hour_tens, r.shown_hour_units, r.shown_minute_tens,
			r.shown_minute_units, r.shown_second_tens, r.shown_second_units,
			r.editing, r.field_selected, r.load_rejected);
	endfunction

	task automatic predict_shown(input in_item_t it);
		logic [32:0] next_count;
		logic        rejected;
		logic        load_ok;
		digits_t     sel;
		out_item_t   want;
		rejected = 1'b0;
		case (it.op)
			OP_TICK: begin
				if (!edit_on) begin
					next_count = {1'b0, tick_count} + 33'd1;
					if (next_count >= {17'd0, tps} || next_count > COUNT_TOP) begin
						tick_count = '0;
						live_time = step_up(live_time, FIELD_SEC);
					end else begin
						tick_count = next_count[31:0];
					end
				end
			end
			OP_ENTER: begin
				if (!edit_on) begin
					edit_time = live_time;
					field_sel = FIELD_SEC;
					edit_on = 1'b1;
				end
			end
			OP_COARSER: begin
				if (edit_on && field_sel < FIELD_HR) begin
					field_sel = field_sel + 2'd1;
				end
			end
			OP_FINER: begin
				if (edit_on && field_sel > FIELD_SEC) begin
					field_sel = field_sel - 2'd1;
				end
			end
			OP_UP: begin
				if (edit_on && field_sel <= FIELD_HR) begin
					edit_time = step_up(edit_time, field_sel);
				end
			end
			OP_DOWN: begin
				if (edit_on && field_sel <= FIELD_HR) begin
					edit_time = step_down(edit_time, field_sel);
				end
			end
			OP_COMMIT: begin
				if (edit_on) begin
					live_time = edit_time;
					edit_on = 1'b0;
				end
			end
			OP_CANCEL: begin
				edit_on = 1'b0;
			end
			OP_LOAD: begin
				load_ok = !edit_on && it.load_hour_tens <= HT_MAX
					&& it.load_hour_units <= DIG_MAX
					&& (it.load_hour_tens < HT_MAX || it.load_hour_units <= HU_AT_TOP)
					&& it.load_minute_tens <= TENS_MAX && it.load_minute_units <= DIG_MAX
					&& it.load_second_tens <= TENS_MAX && it.load_second_units <= DIG_MAX;
				if (load_ok) begin
					live_time[0] = it.load_second_units;
					live_time[1] = {1'b0, it.load_second_tens};
					live_time[2] = it.load_minute_units;
					live_time[3] = {1'b0, it.load_minute_tens};
					live_time[4] = it.load_hour_units;
					live_time[5] = {2'b00, it.load_hour_tens};
				end else begin
					rejected = 1'b1;
				end
			end
			default: begin
			end
		endcase
		sel = edit_on ? edit_time : live_time;
		want.shown_hour_tens    = sel[5][1:0];
		want.shown_hour_units   = sel[4];
		want.shown_minute_tens  = sel[3][2:0];
		want.shown_minute_units = sel[2];
		want.shown_second_tens  = sel[1][2:0];
		want.shown_second_units = sel[0];
		want.editing            = edit_on;
		want.field_selected     = field_sel;
		want.load_rejected      = rejected;
		shown_q.push_back(want);
	endtask

	task automatic check_shown(input out_item_t got);
		out_item_t want;
		if (shown_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: result item with nothing expected: %s", $realtime,
					show_time(got));
			end
		end else begin
			want = shown_q.pop_front();
			if (got.shown_hour_tens !== want.shown_hour_tens
					|| got.shown_hour_units !== want.shown_hour_units
					|| got.shown_minute_tens !== want.shown_minute_tens
					|| got.shown_minute_units !== want.shown_minute_units
					|| got.shown_second_tens !== want.shown_second_tens
					|| got.shown_second_units !== want.shown_second_units
					|| got.editing !== want.editing
					|| got.field_selected !== want.field_selected
					|| got.load_rejected !== want.load_rejected) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: mismatch expected %s actual %s", $realtime,
						show_time(want), show_time(got));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_time = '0;
			edit_time = '0;
			edit_on = 1'b0;
			field_sel = FIELD_SEC;
			tick_count = '0;
			tps = TPS_RESET;
			shown_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_write) begin
				tps = cfg_data;
			end
			if (out_ch.valid && out_ch.ready) begin
				check_shown({out_ch.shown_hour_tens, out_ch.shown_hour_units,
					out_ch.shown_minute_tens, out_ch.shown_minute_units,
					out_ch.shown_second_tens, out_ch.shown_second_units,
					out_ch.editing, out_ch.field_selected, out_ch.load_rejected});
			end
			if (in_ch.valid && in_ch.ready) begin
				predict_shown({in_ch.op, in_ch.load_hour_tens, in_ch.load_hour_units,
					in_ch.load_minute_tens, in_ch.load_minute_units,
					in_ch.load_second_tens, in_ch.load_second_units});
			end
			pending = shown_q.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
// testbench top for the time-of-day clock: stimulus, configuration and verdict
`timescale 1ns / 100ps

module tb_top;
	import btod_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [3:0] OP_SPARE_LO = OP_LOAD + 4'd1;
	localparam logic [3:0] OP_SPARE_HI = 4'hF;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_write;
	logic [TPS_W-1:0] cfg_data;
	int               fail_count;
	int               pending;
	int               cycle_count = 0;
	bit               steady;

	btod_in_if  in_ch ();
	btod_out_if out_ch ();

	bcd_time_of_day_clock_with_edit_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	btod_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_ch.ready = steady || ($urandom_range(99) >= 23);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic in_item_t op_item(logic [3:0] op);
		logic [31:0] r;
		in_item_t    it;
		r = $urandom;
		it = r[$bits(in_item_t)-1:0];
		it.op = op;
		return it;
	endfunction

	function automatic in_item_t load_item(logic [1:0] ht, logic [3:0] hu, logic [2:0] mt,
			logic [3:0] mu, logic [2:0] st, logic [3:0] su);
		in_item_t it;
		it = {OP_LOAD, ht, hu, mt, mu, st, su};
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       pick;
		it = op_item(OP_TICK);
		pick = $urandom_range(99);
		if (pick < 35) begin
			it.op = OP_TICK;
		end else if (pick < 43) begin
			it.op = OP_ENTER;
		end else if (pick < 51) begin
			it.op = OP_COARSER;
		end else if (pick < 59) begin
			it.op = OP_FINER;
		end else if (pick < 71) begin
			it.op = OP_UP;
		end else if (pick < 83) begin
			it.op = OP_DOWN;
		end else if (pick < 88) begin
			it.op = OP_COMMIT;
		end else if (pick < 92) begin
			it.op = OP_CANCEL;
		end else if (pick < 98) begin
			it.op = OP_LOAD;
		end else begin
			it.op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
		end
		if (it.op == OP_LOAD && $urandom_range(3) != 0) begin
			if ($urandom_range(3) == 0) begin
				it = load_item(2'(HT_MAX), HU_AT_TOP, 3'(TENS_MAX), DIG_MAX, 3'(TENS_MAX),
					4'($urandom_range(DIG_MAX)));
			end else begin
				it.load_hour_tens = 2'($urandom_range(HT_MAX));
				it.load_hour_units = (it.load_hour_tens == HT_MAX) ?
					4'($urandom_range(HU_AT_TOP)) : 4'($urandom_range(DIG_MAX));
				it.load_minute_tens = 3'($urandom_range(TENS_MAX));
				it.load_minute_units = 4'($urandom_range(DIG_MAX));
				it.load_second_tens = 3'($urandom_range(TENS_MAX));
				it.load_second_units = 4'($urandom_range(DIG_MAX));
			end
		end
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		while (!steady && $urandom_range(99) < 23) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		{in_ch.op, in_ch.load_hour_tens, in_ch.load_hour_units, in_ch.load_minute_tens,
			in_ch.load_minute_units, in_ch.load_second_tens, in_ch.load_second_units} = it;
		in_ch.valid = 1'b1;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic drain(input int settle);
		in_ch.valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_tps(input logic [TPS_W-1:0] value);
		drain(4);
		cfg_write = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	initial begin
		logic [TPS_W-1:0] tps_set[6];
		int               p;
		int               i;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = '0;
		steady = 1'b0;
		in_ch.valid = 1'b0;
		{in_ch.op, in_ch.load_hour_tens, in_ch.load_hour_units, in_ch.load_minute_tens,
			in_ch.load_minute_units, in_ch.load_second_tens, in_ch.load_second_units} = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default prescaler, no advance
		send_item(op_item(OP_TICK));
		write_tps(16'd1);
		// wrap at midnight
		send_item(load_item(2'd2, 4'd3, 3'd5, 4'd9, 3'd5, 4'd9));
		send_item(op_item(OP_TICK));
		// refused loads
		send_item(load_item(2'h3, 4'hF, 3'h7, 4'hF, 3'h7, 4'hF));
		send_item(load_item(2'd2, 4'd4, 3'd0, 4'd0, 3'd0, 4'd0));
		// carry into the hour tens
		send_item(load_item(2'd1, 4'd9, 3'd5, 4'd9, 3'd5, 4'd8));
		send_item(op_item(OP_TICK));
		send_item(op_item(OP_TICK));
		send_item(load_item(2'd0, 4'd0, 3'd0, 4'd0, 3'd0, 4'd0));
		// edit ops outside edit mode
		send_item(op_item(OP_COARSER));
		send_item(op_item(OP_UP));
		send_item(op_item(OP_COMMIT));
		// edit session with saturation, borrow and hour wrap
		send_item(op_item(OP_ENTER));
		send_item(op_item(OP_ENTER));
		send_item(op_item(OP_TICK));
		send_item(load_item(2'd1, 4'd2, 3'd3, 4'd4, 3'd5, 4'd6));
		send_item(op_item(OP_FINER));
		send_item(op_item(OP_DOWN));
		send_item(op_item(OP_UP));
		send_item(op_item(OP_COARSER));
		send_item(op_item(OP_COARSER));
		send_item(op_item(OP_COARSER));
		send_item(op_item(OP_DOWN));
		send_item(op_item(OP_FINER));
		send_item(op_item(OP_UP));
		send_item(op_item(OP_COMMIT));
		send_item(op_item(OP_ENTER));
		send_item(op_item(OP_CANCEL));
		send_item(op_item(OP_SPARE_LO));
		send_item(op_item(OP_SPARE_HI));

		tps_set[0] = 16'd2;
		tps_set[1] = 16'd1;
		tps_set[2] = 16'd0;
		tps_set[3] = 16'hFFFF;
		tps_set[4] = 16'd3;
		tps_set[5] = 16'($urandom_range(60, 4));
		for (p = 0; p < 6; p++) begin
			write_tps(tps_set[p]);
			steady = (p == 2);
			for (i = 0; i < 220; i++) begin
				if (p == 4 && i == 110) begin
					drain(0);
				end
				send_item(random_item());
			end
			steady = 1'b0;
		end

		drain(8);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
